@@ rtl/core/asc_pkg.sv @@
// Shared types and constants for the alarm and snooze controller.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package asc_pkg;

   // event codes as they arrive on the request word
   localparam logic [3:0] FN_TICK    = 4'd0;
   localparam logic [3:0] FN_ENTER   = 4'd1;
   localparam logic [3:0] FN_DIGIT   = 4'd2;
   localparam logic [3:0] FN_NEXT    = 4'd3;
   localparam logic [3:0] FN_CONFIRM = 4'd4;
   localparam logic [3:0] FN_CANCEL  = 4'd5;
   localparam logic [3:0] FN_TOGGLE  = 4'd6;
   localparam logic [3:0] FN_STOP    = 4'd7;
   localparam logic [3:0] FN_SNOOZE  = 4'd8;

   // edit modes
   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_HOUR   = 2'd1;
   localparam logic [1:0] MODE_MINUTE = 2'd2;

   // field limits
   localparam logic [4:0] HOUR_MAX     = 5'd23;
   localparam logic [5:0] MINUTE_MAX   = 6'd59;
   localparam logic [3:0] DIGIT_MAX    = 4'd9;
   localparam logic [1:0] ENTRY_DIGITS = 2'd2;

   // configuration register indexes and reset values
   localparam logic       CSR_SNOOZE_LIMIT = 1'b0;
   localparam logic       CSR_SNOOZE_MS    = 1'b1;
   localparam logic [3:0]  SNOOZE_LIMIT_RST = 4'd3;
   localparam logic [21:0] SNOOZE_MS_RST    = 22'd300000;

   // alarm time after reset
   localparam logic [4:0] ALARM_HOUR_RST   = 5'd7;
   localparam logic [5:0] ALARM_MINUTE_RST = 6'd30;

   // classified operation, one bit per kind
   typedef enum logic [9:0] {
      OP_NONE    = 10'b00_0000_0001,
      OP_TICK    = 10'b00_0000_0010,
      OP_ENTER   = 10'b00_0000_0100,
      OP_DIGIT   = 10'b00_0000_1000,
      OP_NEXT    = 10'b00_0001_0000,
      OP_CONFIRM = 10'b00_0010_0000,
      OP_CANCEL  = 10'b00_0100_0000,
      OP_TOGGLE  = 10'b00_1000_0000,
      OP_STOP    = 10'b01_0000_0000,
      OP_SNOOZE  = 10'b10_0000_0000
   } op_type;

   typedef struct packed {
      logic [3:0]  func;
      logic [3:0]  digit;
      logic [4:0]  cur_hour;
      logic [5:0]  cur_minute;
      logic [5:0]  cur_second;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        is_ringing;
      logic        is_snoozing;
      logic        is_armed;
      logic [1:0]  edit_state;
      logic [4:0]  show_hour;
      logic [5:0]  show_minute;
      logic [3:0]  snoozes_used;
      logic        sound_start;
      logic        sound_stop;
   } rsp_type;

   // classified word passed from the front end to the back end
   typedef struct packed {
      op_type      op;
      logic [3:0]  digit;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic        sec_zero;
      logic [31:0] now_ms;
   } cmd_type;

   // configuration write
   typedef struct packed {
      logic        we;
      logic        index;
      logic [21:0] wdata;
   } csr_type;

endpackage

@@ rtl/core/asc_front.sv @@
// Front end: accepts request words and classifies them into commands.
// Depends on asc_pkg.
`timescale 1ns / 1ps

module asc_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  asc_pkg::req_type  req_data,
   input  logic              q_full,
   output logic              q_push,
   output asc_pkg::cmd_type  q_cmd
);
   import asc_pkg::*;

   // take a word whenever the queue has room
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // decode the event code, clamp the key, flag second zero
   always_comb begin
      case (req_data.func)
         FN_TICK:    q_cmd.op = OP_TICK;
         FN_ENTER:   q_cmd.op = OP_ENTER;
         FN_DIGIT:   q_cmd.op = OP_DIGIT;
         FN_NEXT:    q_cmd.op = OP_NEXT;
         FN_CONFIRM: q_cmd.op = OP_CONFIRM;
         FN_CANCEL:  q_cmd.op = OP_CANCEL;
         FN_TOGGLE:  q_cmd.op = OP_TOGGLE;
         FN_STOP:    q_cmd.op = OP_STOP;
         FN_SNOOZE:  q_cmd.op = OP_SNOOZE;
         default:    q_cmd.op = OP_NONE;
      endcase
      q_cmd.digit    = (req_data.digit > DIGIT_MAX) ? DIGIT_MAX : req_data.digit;
      q_cmd.hour     = req_data.cur_hour;
      q_cmd.minute   = req_data.cur_minute;
      q_cmd.sec_zero = (req_data.cur_second == 6'd0);
      q_cmd.now_ms   = req_data.now_ms;
   end

endmodule

@@ rtl/core/asc_queue.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on asc_pkg for the command word type.
`timescale 1ns / 1ps

module asc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  asc_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output asc_pkg::cmd_type  head_cmd
);
   import asc_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_cmd  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/core/asc_back.sv @@
// Back end: holds the alarm, edit and snooze state, executes one command per cycle
// unless the response is stalled, and drives the registered response word. Depends on asc_pkg.
`timescale 1ns / 1ps

module asc_back (
   input  logic              clock,
   input  logic              reset,
   input  asc_pkg::csr_type  csr,
   input  logic              cmd_valid,
   input  asc_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output asc_pkg::rsp_type  rsp_data
);
   import asc_pkg::*;

   // configuration
   logic [3:0]  snooze_limit_ff;
   logic [21:0] snooze_ms_ff;

   // alarm state
   logic [4:0]  alarm_hour_ff, alarm_hour_in;
   logic [5:0]  alarm_minute_ff, alarm_minute_in;
   logic        armed_ff, armed_in;
   logic [1:0]  edit_mode_ff, edit_mode_in;
   logic [4:0]  edit_hour_ff, edit_hour_in;
   logic [5:0]  edit_minute_ff, edit_minute_in;
   logic [1:0]  entry_count_ff, entry_count_in;
   logic [6:0]  entry_value_ff, entry_value_in;
   logic        ringing_ff, ringing_in;
   logic        snoozing_ff, snoozing_in;
   logic [3:0]  snooze_count_ff, snooze_count_in;
   logic [31:0] snooze_deadline_ff, snooze_deadline_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        start, stop;
   logic [6:0]  entry_base;
   logic [6:0]  entry_next;
   logic        time_match;

   assign cmd_pop   = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         snooze_limit_ff <= SNOOZE_LIMIT_RST;
         snooze_ms_ff    <= SNOOZE_MS_RST;
      end else if (csr.we) begin
         if (csr.index == CSR_SNOOZE_LIMIT) begin
            snooze_limit_ff <= csr.wdata[3:0];
         end else begin
            snooze_ms_ff <= csr.wdata;
         end
      end
   end

   // entry buffer restarts after two digits
   assign entry_base = (entry_count_ff >= ENTRY_DIGITS) ? 7'd0 : entry_value_ff;
   assign entry_next = 7'((entry_base << 3) + (entry_base << 1)) + {3'd0, cmd.digit};
   assign time_match = (cmd.hour == alarm_hour_ff) && (cmd.minute == alarm_minute_ff)
                       && cmd.sec_zero;

   // state update for the command at the queue head
   always_comb begin
      alarm_hour_in      = alarm_hour_ff;
      alarm_minute_in    = alarm_minute_ff;
      armed_in           = armed_ff;
      edit_mode_in       = edit_mode_ff;
      edit_hour_in       = edit_hour_ff;
      edit_minute_in     = edit_minute_ff;
      entry_count_in     = entry_count_ff;
      entry_value_in     = entry_value_ff;
      ringing_in         = ringing_ff;
      snoozing_in        = snoozing_ff;
      snooze_count_in    = snooze_count_ff;
      snooze_deadline_in = snooze_deadline_ff;
      start              = 1'b0;
      stop               = 1'b0;
      case (cmd.op)
         OP_TICK: begin
            if (snoozing_ff) begin
               if (cmd.now_ms >= snooze_deadline_ff) begin
                  snoozing_in = 1'b0;
                  ringing_in  = 1'b1;
                  start       = 1'b1;
               end
            end else if (armed_ff && !ringing_ff && time_match) begin
               ringing_in = 1'b1;
               start      = 1'b1;
            end
         end
         OP_ENTER: begin
            edit_hour_in   = alarm_hour_ff;
            edit_minute_in = alarm_minute_ff;
            edit_mode_in   = MODE_HOUR;
            entry_count_in = 2'd0;
            entry_value_in = 7'd0;
         end
         OP_DIGIT: begin
            if (edit_mode_ff != MODE_NONE) begin
               entry_value_in = entry_next;
               entry_count_in = (entry_count_ff >= ENTRY_DIGITS) ? 2'd1
                                                                : entry_count_ff + 2'd1;
               if (edit_mode_ff == MODE_HOUR) begin
                  edit_hour_in = (entry_next > 7'(HOUR_MAX)) ? HOUR_MAX : entry_next[4:0];
               end else begin
                  edit_minute_in = (entry_next > 7'(MINUTE_MAX)) ? MINUTE_MAX
                                                                 : entry_next[5:0];
               end
            end
         end
         OP_NEXT: begin
            entry_count_in = 2'd0;
            entry_value_in = 7'd0;
            edit_mode_in   = (edit_mode_ff == MODE_HOUR) ? MODE_MINUTE : MODE_HOUR;
         end
         OP_CONFIRM: begin
            alarm_hour_in   = edit_hour_ff;
            alarm_minute_in = edit_minute_ff;
            edit_mode_in    = MODE_NONE;
         end
         OP_CANCEL: begin
            edit_mode_in = MODE_NONE;
         end
         OP_TOGGLE: begin
            armed_in = !armed_ff;
         end
         OP_STOP: begin
            ringing_in      = 1'b0;
            snoozing_in     = 1'b0;
            snooze_count_in = 4'd0;
            stop            = 1'b1;
         end
         OP_SNOOZE: begin
            if (snooze_count_ff >= snooze_limit_ff) begin
               ringing_in      = 1'b0;
               snoozing_in     = 1'b0;
               snooze_count_in = 4'd0;
            end else begin
               snooze_count_in    = snooze_count_ff + 4'd1;
               snoozing_in        = 1'b1;
               ringing_in         = 1'b0;
               snooze_deadline_in = cmd.now_ms + {10'd0, snooze_ms_ff};
            end
            stop = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // response word built from the state after the command
   always_comb begin
      rsp_data_in.is_ringing   = ringing_in;
      rsp_data_in.is_snoozing  = snoozing_in;
      rsp_data_in.is_armed     = armed_in;
      rsp_data_in.edit_state   = edit_mode_in;
      rsp_data_in.show_hour    = (edit_mode_in != MODE_NONE) ? edit_hour_in : alarm_hour_in;
      rsp_data_in.show_minute  = (edit_mode_in != MODE_NONE) ? edit_minute_in
                                                             : alarm_minute_in;
      rsp_data_in.snoozes_used = snooze_count_in;
      rsp_data_in.sound_start  = start;
      rsp_data_in.sound_stop   = stop;
      rsp_valid_in             = cmd_pop || (rsp_valid_ff && !rsp_ready);
   end

   // state registers advance only on a popped command
   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_hour_ff      <= ALARM_HOUR_RST;
         alarm_minute_ff    <= ALARM_MINUTE_RST;
         armed_ff           <= 1'b0;
         edit_mode_ff       <= MODE_NONE;
         edit_hour_ff       <= ALARM_HOUR_RST;
         edit_minute_ff     <= ALARM_MINUTE_RST;
         entry_count_ff     <= 2'd0;
         entry_value_ff     <= 7'd0;
         ringing_ff         <= 1'b0;
         snoozing_ff        <= 1'b0;
         snooze_count_ff    <= 4'd0;
         snooze_deadline_ff <= 32'd0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd_pop) begin
            alarm_hour_ff      <= alarm_hour_in;
            alarm_minute_ff    <= alarm_minute_in;
            armed_ff           <= armed_in;
            edit_mode_ff       <= edit_mode_in;
            edit_hour_ff       <= edit_hour_in;
            edit_minute_ff     <= edit_minute_in;
            entry_count_ff     <= entry_count_in;
            entry_value_ff     <= entry_value_in;
            ringing_ff         <= ringing_in;
            snoozing_ff        <= snoozing_in;
            snooze_count_ff    <= snooze_count_in;
            snooze_deadline_ff <= snooze_deadline_in;
         end
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

@@ rtl/core/alarm_snooze_controller.sv @@
// Alarm clock controller with snooze. Each request word carries one event
// (tick, enter set, digit, next field, confirm, cancel, toggle, stop, snooze)
// and yields exactly one response word with the state after that event and
// the buzzer start and stop pulses. The block sustains one word per clock
// while responses are taken: a decoder feeds a two-entry queue, and the
// execute stage updates the state and loads the response register; a word
// passes a queue slot, then the response register. When the response is
// held back the queue absorbs two more words before req_ready falls.
// Configuration writes (index 0 snooze limit, index 1 snooze_ms) take effect
// on the next edge. Depends on asc_pkg, asc_front, asc_queue and asc_back.
`timescale 1ns / 1ps

module alarm_snooze_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  asc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output asc_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [21:0]       csr_wdata
);
   import asc_pkg::*;

   logic    q_full, q_push, q_pop, q_not_empty;
   cmd_type q_cmd, head_cmd;
   csr_type csr;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   // decode
   asc_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   // decoupling queue
   asc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   // execute
   asc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .cmd_valid (q_not_empty),
      .cmd       (head_cmd),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/core/asc_checker.sv @@
// Port-level checks for the alarm and snooze controller, bound to the top.
// Depends on asc_pkg and alarm_snooze_controller.
`timescale 1ns / 1ps

module asc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input asc_pkg::rsp_type  rsp_data
);
   import asc_pkg::*;

   // a stalled response word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a start pulse always leaves the alarm ringing
   a_start_rings: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sound_start |-> rsp_data.is_ringing)
      else $error("sound start without ringing");

   // a stop pulse never leaves the alarm ringing
   a_stop_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sound_stop |-> !rsp_data.is_ringing && !rsp_data.sound_start)
      else $error("sound stop with ringing");

   // shown time stays within clock range
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.show_hour <= HOUR_MAX && rsp_data.show_minute <= MINUTE_MAX)
      else $error("shown time out of range");

   // ringing and snoozing never both set
   a_ring_snooze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_ringing && rsp_data.is_snoozing))
      else $error("ringing while snoozing");

endmodule

bind alarm_snooze_controller asc_checker u_asc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ verif/tb.sv @@
// Self-checking bench for alarm_snooze_controller: directed events, then phases of random
// event sequences under several register settings, with an in-bench model of the alarm state.
// Depends on asc_pkg and the alarm_snooze_controller rtl.
`timescale 1ns / 1ps

module tb;
   import asc_pkg::*;

   // func codes the block leaves unused
   localparam logic [3:0] FN_UNUSED_LO = 4'd9;
   localparam logic [3:0] FN_UNUSED_HI = 4'd15;

   // tracks alarm state per accepted word and holds the status words still owed
   class status_scoreboard;
      logic [3:0]  snooze_limit;
      logic [21:0] snooze_len;
      logic [4:0]  alarm_hour;
      logic [5:0]  alarm_minute;
      logic        armed;
      logic [1:0]  mode;
      logic [4:0]  edit_hour;
      logic [5:0]  edit_minute;
      logic [1:0]  entry_count;
      logic [6:0]  entry_value;
      logic        ringing;
      logic        snoozing;
      logic [3:0]  snooze_count;
      logic [31:0] deadline;
      rsp_type     expected_status[$];
      int          fail_count;

      function new();
         snooze_limit = SNOOZE_LIMIT_RST;
         snooze_len   = SNOOZE_MS_RST;
         alarm_hour   = ALARM_HOUR_RST;
         alarm_minute = ALARM_MINUTE_RST;
         armed        = 1'b0;
         mode         = MODE_NONE;
         edit_hour    = ALARM_HOUR_RST;
         edit_minute  = ALARM_MINUTE_RST;
         entry_count  = '0;
         entry_value  = '0;
         ringing      = 1'b0;
         snoozing     = 1'b0;
         snooze_count = '0;
         deadline     = '0;
         fail_count   = 0;
      endfunction

      function void load_reg(logic idx, logic [21:0] value);
         if (idx == CSR_SNOOZE_LIMIT) begin
            snooze_limit = value[3:0];
         end else begin
            snooze_len = value;
         end
      endfunction

      function int pending();
         return expected_status.size();
      endfunction

      function void stop_all();
         ringing      = 1'b0;
         snoozing     = 1'b0;
         snooze_count = '0;
      endfunction

      // advance the alarm state by one event and queue the status it leaves
      function void note_event(req_type ev);
         rsp_type    st;
         logic       start;
         logic       stop;
         logic [3:0] key;
         start = 1'b0;
         stop  = 1'b0;
         case (ev.func)
            FN_TICK: begin
               if (snoozing) begin
                  if (ev.now_ms >= deadline) begin
                     snoozing = 1'b0;
                     ringing  = 1'b1;
                     start    = 1'b1;
                  end
               end else if (armed && !ringing && ev.cur_hour == alarm_hour &&
                            ev.cur_minute == alarm_minute && ev.cur_second == 6'd0) begin
                  ringing = 1'b1;
                  start   = 1'b1;
               end
            end
            FN_ENTER: begin
               edit_hour   = alarm_hour;
               edit_minute = alarm_minute;
               mode        = MODE_HOUR;
               entry_count = '0;
               entry_value = '0;
            end
            FN_DIGIT: begin
               if (mode != MODE_NONE) begin
                  // a third digit starts a fresh entry
                  if (entry_count >= ENTRY_DIGITS) begin
                     entry_count = '0;
                     entry_value = '0;
                  end
                  key = (ev.digit > DIGIT_MAX) ? DIGIT_MAX : ev.digit;
                  entry_value = entry_value * 7'd10 + {3'd0, key};
                  entry_count = entry_count + 2'd1;
                  if (mode == MODE_HOUR) begin
                     edit_hour = (entry_value > 7'(HOUR_MAX)) ? HOUR_MAX : entry_value[4:0];
                  end else begin
                     edit_minute = (entry_value > 7'(MINUTE_MAX)) ? MINUTE_MAX
                                                                  : entry_value[5:0];
                  end
               end
            end
            FN_NEXT: begin
               entry_count = '0;
               entry_value = '0;
               mode = (mode == MODE_HOUR) ? MODE_MINUTE : MODE_HOUR;
            end
            FN_CONFIRM: begin
               alarm_hour   = edit_hour;
               alarm_minute = edit_minute;
               mode         = MODE_NONE;
            end
            FN_CANCEL: mode = MODE_NONE;
            FN_TOGGLE: armed = !armed;
            FN_STOP: begin
               stop_all();
               stop = 1'b1;
            end
            FN_SNOOZE: begin
               if (snooze_count >= snooze_limit) begin
                  stop_all();
               end else begin
                  snooze_count = snooze_count + 4'd1;
                  snoozing     = 1'b1;
                  ringing      = 1'b0;
                  deadline     = ev.now_ms + {10'd0, snooze_len};
               end
               stop = 1'b1;
            end
            default: ;
         endcase
         st.is_ringing   = ringing;
         st.is_snoozing  = snoozing;
         st.is_armed     = armed;
         st.edit_state   = mode;
         st.show_hour    = (mode != MODE_NONE) ? edit_hour : alarm_hour;
         st.show_minute  = (mode != MODE_NONE) ? edit_minute : alarm_minute;
         st.snoozes_used = snooze_count;
         st.sound_start  = start;
         st.sound_stop   = stop;
         expected_status.push_back(st);
      endfunction

      function void check_field(string name, logic [5:0] want, logic [5:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
         end
      endfunction

      function void check_status(rsp_type got);
         rsp_type want;
         if (expected_status.size() == 0) begin
            $error("status word with nothing outstanding: %h", got);
            fail_count++;
            return;
         end
         want = expected_status.pop_front();
         check_field("is_ringing", 6'(want.is_ringing), 6'(got.is_ringing));
         check_field("is_snoozing", 6'(want.is_snoozing), 6'(got.is_snoozing));
         check_field("is_armed", 6'(want.is_armed), 6'(got.is_armed));
         check_field("edit_state", 6'(want.edit_state), 6'(got.edit_state));
         check_field("show_hour", 6'(want.show_hour), 6'(got.show_hour));
         check_field("show_minute", want.show_minute, got.show_minute);
         check_field("snoozes_used", 6'(want.snoozes_used), 6'(got.snoozes_used));
         check_field("sound_start", 6'(want.sound_start), 6'(got.sound_start));
         check_field("sound_stop", 6'(want.sound_stop), 6'(got.sound_stop));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic        csr_index;
   logic [21:0] csr_wdata;

   status_scoreboard sb = new();

   bit          tx_steady;
   bit          rx_steady;
   bit          rx_hold;
   int          counted;
   logic [31:0] wall_ms;

   alarm_snooze_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic req_type make_event(logic [3:0] func, logic [31:0] now);
      req_type ev;
      ev.func       = func;
      ev.digit      = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(10, 15)
                                                     : $urandom_range(0, 9));
      ev.cur_hour   = 5'($urandom_range(0, 23));
      ev.cur_minute = 6'($urandom_range(0, 59));
      ev.cur_second = 6'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 59));
      ev.now_ms     = now;
      return ev;
   endfunction

   function automatic req_type make_tick(logic [4:0] h, logic [5:0] m, logic [5:0] s,
                                         logic [31:0] now);
      req_type ev;
      ev = make_event(FN_TICK, now);
      ev.cur_hour   = h;
      ev.cur_minute = m;
      ev.cur_second = s;
      return ev;
   endfunction

   function automatic req_type make_digit(logic [3:0] d);
      req_type ev;
      ev = make_event(FN_DIGIT, wall_ms);
      ev.digit = d;
      return ev;
   endfunction

   // offer one word and hold it until taken; valid stays up for the next word
   task automatic push_event(req_type ev);
      int gap;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_event(ev);
      if (ev.func <= FN_SNOOZE) counted++;
   endtask

   // stop offering and wait until every owed status word is back
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [21:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.load_reg(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // status side: random back-pressure, plus a long hold-off on request
   initial begin : status_side
      int   run_left;
      int   hold_left;
      logic ready_next;
      run_left   = 0;
      hold_left  = 0;
      ready_next = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_status(rsp_data);
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
            if (hold_left == 0) rx_hold = 1'b0;
         end else if (rx_hold) begin
            hold_left  = 80;
            ready_next = 1'b0;
         end else if (rx_steady) begin
            ready_next = 1'b1;
         end else if (run_left > 0) begin
            run_left--;
         end else begin
            ready_next = !ready_next;
            run_left   = ready_next ? $urandom_range(0, 15) : pick_gap();
         end
         rsp_ready <= ready_next;
      end
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      req_type     ev;
      logic [56:0] raw;
      logic [3:0]  f;
      logic [3:0]  mx;
      logic [21:0] len;
      logic [21:0] wd;
      int          kind;
      int          n;
      int          rounds;
      int          phase_idx;
      int          phase_start;
      bit          hold_done;

      tx_steady = 1'b0;
      rx_steady = 1'b0;
      rx_hold   = 1'b0;
      counted   = 0;
      wall_ms   = 32'd1000;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_SNOOZE_LIMIT;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: alarm match, snooze and deadline, edit corner cases, all at reset settings
      push_event(make_tick(ALARM_HOUR_RST, ALARM_MINUTE_RST, 6'd0, 32'd1000));
      push_event(make_event(FN_TOGGLE, 32'd1010));
      push_event(make_tick(ALARM_HOUR_RST, ALARM_MINUTE_RST, 6'd5, 32'd1020));
      push_event(make_tick(ALARM_HOUR_RST, ALARM_MINUTE_RST, 6'd0, 32'd1030));
      push_event(make_tick(ALARM_HOUR_RST, ALARM_MINUTE_RST, 6'd0, 32'd1040));
      push_event(make_event(FN_SNOOZE, 32'd5000));
      push_event(make_tick(5'd7, 6'd35, 6'd0, 32'd5000 + {10'd0, SNOOZE_MS_RST} - 32'd1));
      push_event(make_tick(5'd7, 6'd35, 6'd0, 32'd5000 + {10'd0, SNOOZE_MS_RST}));
      push_event(make_event(FN_STOP, 32'd305010));
      // snooze while idle, with a deadline that wraps past zero
      push_event(make_event(FN_SNOOZE, 32'hFFFF_FFF0));
      push_event(make_tick(5'h1F, 6'h3F, 6'h3F, 32'hFFFF_FFFF));
      // the last of these hits the snooze limit and stops
      repeat (3) push_event(make_event(FN_SNOOZE, 32'd0));
      push_event(make_digit(4'd4));
      push_event(make_event(FN_NEXT, 32'd0));
      push_event(make_event(FN_ENTER, 32'd0));
      push_event(make_digit(4'd9));
      push_event(make_digit(4'd9));
      push_event(make_digit(4'd15));
      push_event(make_event(FN_NEXT, 32'd0));
      push_event(make_digit(4'd7));
      push_event(make_digit(4'd5));
      push_event(make_event(FN_CONFIRM, 32'd0));
      push_event(make_event(FN_CONFIRM, 32'd0));
      push_event(make_event(FN_CANCEL, 32'd0));
      push_event(make_event(FN_UNUSED_LO, 32'd0));
      push_event(make_event(FN_UNUSED_HI, 32'd0));

      // random phases, one register setting each
      for (phase_idx = 0; phase_idx < 6; phase_idx++) begin
         settle();
         case (phase_idx)
            0: begin mx = 4'd15; len = 22'd0; end
            1: begin mx = 4'd0; len = 22'd1; end
            2: begin mx = 4'd15; len = 22'h3FFFFF; end
            3: begin mx = 4'd2; len = 22'd3600000; end
            4: begin mx = 4'($urandom_range(0, 15)); len = 22'($urandom); end
            default: begin mx = SNOOZE_LIMIT_RST; len = SNOOZE_MS_RST; end
         endcase
         wd = 22'($urandom);
         wd[3:0] = mx;
         write_reg(CSR_SNOOZE_LIMIT, wd);
         write_reg(CSR_SNOOZE_MS, len);
         tx_steady   = (phase_idx == 2);
         rx_steady   = (phase_idx == 2);
         phase_start = counted;
         hold_done   = 1'b0;

         while (counted - phase_start < 305) begin
            // long stall on the status side while words keep coming
            if ((phase_idx == 1 || phase_idx == 4) && !hold_done &&
                counted - phase_start >= 100) begin
               rx_hold   = 1'b1;
               hold_done = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
               // set the alarm time through the edit sequence
               push_event(make_event(($urandom_range(0, 9) == 0) ? FN_NEXT : FN_ENTER,
                                     wall_ms));
               n = $urandom_range(0, 3);
               repeat (n) push_event(make_event(FN_DIGIT, wall_ms));
               if ($urandom_range(0, 3) != 0) begin
                  push_event(make_event(FN_NEXT, wall_ms));
                  n = $urandom_range(0, 3);
                  repeat (n) push_event(make_event(FN_DIGIT, wall_ms));
               end
               if ($urandom_range(0, 7) == 0) push_event(make_event(FN_NEXT, wall_ms));
               push_event(make_event(($urandom_range(0, 3) == 0) ? FN_CANCEL : FN_CONFIRM,
                                     wall_ms));
            end else if (kind < 55) begin
               // arm, ring on the alarm time, then snooze rounds up to the deadline
               if (!sb.armed) push_event(make_event(FN_TOGGLE, wall_ms));
               if ((sb.ringing || sb.snoozing) && $urandom_range(0, 1))
                  push_event(make_event(FN_STOP, wall_ms));
               wall_ms += $urandom_range(1, 60000);
               push_event(make_tick(sb.alarm_hour, sb.alarm_minute,
                                    6'(($urandom_range(0, 4) == 0) ? $urandom_range(1, 59)
                                                                   : 0),
                                    wall_ms));
               rounds = $urandom_range(0, 5);
               repeat (rounds) begin
                  wall_ms += $urandom_range(0, 3000);
                  push_event(make_event(FN_SNOOZE, wall_ms));
                  n = $urandom_range(0, 2);
                  repeat (n)
                     push_event(make_event(FN_TICK, sb.deadline - $urandom_range(1, 2000)));
                  wall_ms = sb.deadline + $urandom_range(0, 2);
                  push_event(make_event(FN_TICK, wall_ms));
               end
               push_event(make_event($urandom_range(0, 2) ? FN_STOP : FN_SNOOZE, wall_ms));
            end else if (kind < 75) begin
               // plain clock ticks, sometimes on the alarm time
               n = $urandom_range(1, 8);
               repeat (n) begin
                  wall_ms += $urandom_range(1, 1500);
                  ev = make_event(FN_TICK, wall_ms);
                  if ($urandom_range(0, 4) == 0) begin
                     ev.cur_hour   = sb.alarm_hour;
                     ev.cur_minute = sb.alarm_minute;
                  end
                  push_event(ev);
               end
            end else if (kind < 90) begin
               // raw noise over every field and code
               n = $urandom_range(1, 6);
               repeat (n) begin
                  raw = 57'({$urandom, $urandom});
                  ev = raw;
                  if ($urandom_range(0, 3) != 0) ev.func = 4'($urandom_range(0, 8));
                  if ($urandom_range(0, 9) == 0) wall_ms = ev.now_ms;
                  push_event(ev);
               end
            end else begin
               // short bursts of buttons
               n = $urandom_range(1, 4);
               repeat (n) begin
                  case ($urandom_range(0, 5))
                     0: f = FN_TOGGLE;
                     1: f = FN_STOP;
                     2: f = FN_SNOOZE;
                     3: f = FN_CANCEL;
                     4: f = FN_NEXT;
                     default: f = FN_CONFIRM;
                  endcase
                  push_event(make_event(f, wall_ms));
               end
            end
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/asc_pkg.sv
rtl/core/asc_front.sv
rtl/core/asc_queue.sv
rtl/core/asc_back.sv
rtl/core/alarm_snooze_controller.sv
rtl/core/asc_checker.sv
verif/tb.sv
